// ===== sv/assert_macros.svh =====
// Assertion helpers used by the tag directory RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/satd_pkg.sv =====
package satd_pkg;

   // operation codes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_FILL   = 2'd1;
   localparam logic [1:0] OP_EVICT  = 2'd2;

   // register indexes
   localparam logic CSR_LINES_LOG2 = 1'b0;
   localparam logic CSR_WAYS       = 1'b1;

   localparam logic [3:0] LINES_LOG2_RESET = 4'd8;
   localparam logic [3:0] WAYS_RESET       = 4'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        set_full;
      logic        fill_rejected;
      logic [7:0]  set_number;
      logic [25:0] tag_value;
      logic [31:0] line_address;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== sv/set_assoc_tag_directory.sv =====
// Set-associative tag directory. Pulse start with an operation (lookup, fill or evict) and an
// address while busy is low; the block then runs the item alone and presents one result on
// rsp_payload for exactly one cycle with rsp_strobe, which the receiver must capture then, as
// there is no way to stall it. After start is taken the block steps through ST_SETUP, ST_SCAN
// and ST_DONE, where rsp_strobe is high. The tags of the addressed set sit in one directory
// RAM with a single read port, and in ST_SCAN one way is read and compared per cycle, up to
// the clamped associativity, with the read data registered in the RAM before the compare.
// busy returns low the cycle after the strobe, so a new transaction can follow then. After
// reset the block clears the valid bits of all MAX_LINES entries, busy high throughout.
// Registers may be written whenever the block is idle.
module set_assoc_tag_directory #(
   parameter int ADDR_BITS  = 32,
   parameter int LINE_BYTES = 64,
   parameter int MAX_LINES  = 256,
   parameter int MAX_WAYS   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  satd_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output satd_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [3:0]        csr_wdata
);
   import satd_pkg::*;
   `include "assert_macros.svh"

   localparam int LSB = $clog2(LINE_BYTES + 1) - 1;
   localparam int AW  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int TW  = AW - LSB;
   localparam int LW  = $clog2(MAX_LINES + 1);
   localparam int WW  = $clog2(MAX_WAYS + 1);
   localparam int SW  = (LW > 1) ? LW - 1 : 1;
   localparam int EW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam logic [EW-1:0] CLR_LAST = EW'(MAX_LINES - 1);

   state_type     state_ff, state_in;
   logic [3:0]    lines_log2_ff, lines_log2_in;
   logic [3:0]    ways_ff, ways_in;
   logic [EW-1:0] clr_ff, clr_in;
   logic [WW-1:0] iss_ff, iss_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_last_ff, rd_last_in;
   logic [EW-1:0] rd_ent_ff, rd_ent_in;

   logic [1:0]    op_ff;
   logic [SW-1:0] set_ff;
   logic [TW-1:0] tag_ff;
   logic [31:0]   line_ff;
   logic [WW-1:0] nways_ff;
   logic [EW-1:0] base_ff;
   logic          hit_ff, hit_in;
   logic          full_ff, full_in;
   logic          free_ff, free_in;
   logic [EW-1:0] hit_ent_ff, hit_ent_in;
   logic [EW-1:0] free_ent_ff, free_ent_in;

   logic [SW-1:0]    dec_set;
   logic [TW-1:0]    dec_tag;
   logic [31:0]      dec_line;
   logic [WW-1:0]    dec_nways;
   logic [SW+WW-1:0] base_prod;
   logic [EW+WW-1:0] rd_sum;
   logic             issue;
   logic             accept;

   logic          ram_wr_en;
   logic [EW-1:0] ram_wr_addr;
   logic [TW:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [EW-1:0] ram_rd_addr;
   logic [TW:0]   ram_rd_data;

   satd_decode #(
      .ADDR_BITS  (ADDR_BITS),
      .LINE_BYTES (LINE_BYTES),
      .MAX_LINES  (MAX_LINES),
      .MAX_WAYS   (MAX_WAYS)
   ) u_decode (
      .lines_log2 (lines_log2_ff),
      .ways       (ways_ff),
      .address    (req_payload.address),
      .set_idx    (dec_set),
      .tag        (dec_tag),
      .line_addr  (dec_line),
      .nways      (dec_nways)
   );

   satd_tag_ram #(
      .DEPTH (MAX_LINES),
      .WIDTH (TW + 1),
      .AW    (EW)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign issue     = (state_ff == ST_SCAN) && (iss_ff < nways_ff);
   assign base_prod = set_ff * nways_ff;
   assign rd_sum    = {{WW{1'b0}}, base_ff} + {{EW{1'b0}}, iss_ff};

   // configuration registers
   always_comb begin
      lines_log2_in = lines_log2_ff;
      ways_in       = ways_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LINES_LOG2: lines_log2_in = csr_wdata;
            CSR_WAYS:       ways_in       = csr_wdata;
            default:        lines_log2_in = lines_log2_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_SCAN;
         ST_SCAN:  if (rd_vld_ff && rd_last_ff) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // outputs and RAM control
   always_comb begin
      busy        = 1'b1;
      rsp_strobe  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_sum[EW-1:0];
      case (state_ff)
         ST_CLEAR: ram_wr_en = 1'b1;
         ST_IDLE:  busy = 1'b0;
         ST_SETUP: busy = 1'b1;
         ST_SCAN:  ram_rd_en = issue;
         ST_DONE: begin
            rsp_strobe = 1'b1;
            if (op_ff == OP_FILL && free_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = free_ent_ff;
               ram_wr_data = {1'b1, tag_ff};
            end else if (op_ff == OP_EVICT && hit_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = hit_ent_ff;
               ram_wr_data = {1'b0, tag_ff};
            end
         end
         default: busy = 1'b1;
      endcase
   end

   always_comb begin
      rsp_payload.hit           = hit_ff;
      rsp_payload.set_full      = full_ff;
      rsp_payload.fill_rejected = (op_ff == OP_FILL) && !free_ff;
      rsp_payload.set_number    = 8'(set_ff);
      rsp_payload.tag_value     = 26'(tag_ff);
      rsp_payload.line_address  = line_ff;
   end

   // sequencing counters and the read pipeline tag
   always_comb begin
      clr_in     = clr_ff;
      iss_in     = iss_ff;
      rd_vld_in  = 1'b0;
      rd_last_in = rd_last_ff;
      rd_ent_in  = rd_ent_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + EW'(1);
      end
      if (state_ff == ST_SETUP) begin
         iss_in = '0;
      end
      if (issue) begin
         iss_in     = iss_ff + WW'(1);
         rd_vld_in  = 1'b1;
         rd_last_in = (iss_ff == nways_ff - WW'(1));
         rd_ent_in  = rd_sum[EW-1:0];
      end
   end

   // compare unit: fold one way of the set per cycle
   always_comb begin
      hit_in      = hit_ff;
      full_in     = full_ff;
      free_in     = free_ff;
      hit_ent_in  = hit_ent_ff;
      free_ent_in = free_ent_ff;
      if (state_ff == ST_SETUP) begin
         hit_in  = 1'b0;
         full_in = 1'b1;
         free_in = 1'b0;
      end else if (state_ff == ST_SCAN && rd_vld_ff) begin
         if (ram_rd_data[TW]) begin
            if (!hit_ff && ram_rd_data[TW-1:0] == tag_ff) begin
               hit_in     = 1'b1;
               hit_ent_in = rd_ent_ff;
            end
         end else begin
            full_in = 1'b0;
            if (!free_ff) begin
               free_in     = 1'b1;
               free_ent_in = rd_ent_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         lines_log2_ff <= LINES_LOG2_RESET;
         ways_ff       <= WAYS_RESET;
         clr_ff        <= '0;
         iss_ff        <= '0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lines_log2_ff <= lines_log2_in;
         ways_ff       <= ways_in;
         clr_ff        <= clr_in;
         iss_ff        <= iss_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff  <= rd_last_in;
      rd_ent_ff   <= rd_ent_in;
      hit_ff      <= hit_in;
      full_ff     <= full_in;
      free_ff     <= free_in;
      hit_ent_ff  <= hit_ent_in;
      free_ent_ff <= free_ent_in;
      if (accept) begin
         op_ff    <= req_payload.operation;
         set_ff   <= dec_set;
         tag_ff   <= dec_tag;
         line_ff  <= dec_line;
         nways_ff <= dec_nways;
      end
      if (state_ff == ST_SETUP) begin
         base_ff <= base_prod[EW-1:0];
      end
   end

   `ASSERT_CLKD(a_accept_busy, clock, reset, (start && !busy) |=> busy,
      "accepted transaction did not make the block busy")
   `ASSERT_CLKD(a_rsp_single, clock, reset, rsp_strobe |=> !rsp_strobe,
      "result strobe held for more than one cycle")
   `ASSERT_CLKD(a_reject_full, clock, reset,
      (rsp_strobe && rsp_payload.fill_rejected) |-> rsp_payload.set_full,
      "fill rejected although the set had a free way")
   `ASSERT_CLKD(a_last_read_done, clock, reset,
      (state_ff == ST_SCAN && rd_vld_ff && rd_last_ff) |=> rsp_strobe,
      "scan of the last way not followed by a result")

endmodule

// ===== sv/satd_decode.sv =====
module satd_decode #(
   parameter int ADDR_BITS  = 32,
   parameter int LINE_BYTES = 64,
   parameter int MAX_LINES  = 256,
   parameter int MAX_WAYS   = 8,
   localparam int LSB = $clog2(LINE_BYTES + 1) - 1,
   localparam int AW  = (ADDR_BITS < 32) ? ADDR_BITS : 32,
   localparam int TW  = AW - LSB,
   localparam int LW  = $clog2(MAX_LINES + 1),
   localparam int WW  = $clog2(MAX_WAYS + 1),
   localparam int SW  = (LW > 1) ? LW - 1 : 1
) (
   input  logic [3:0]    lines_log2,
   input  logic [3:0]    ways,
   input  logic [31:0]   address,
   output logic [SW-1:0] set_idx,
   output logic [TW-1:0] tag,
   output logic [31:0]   line_addr,
   output logic [WW-1:0] nways
);
   import satd_pkg::*;

   localparam int CW  = LW + 4;
   localparam int FW  = WW + LW;
   localparam int IBW = $clog2(LW + 1);
   localparam logic [31:0] AMASK = (AW >= 32) ? 32'hFFFF_FFFF : ((32'd1 << AW) - 32'd1);
   localparam logic [31:0] OMASK = (32'd1 << LSB) - 32'd1;

   logic [LW-1:0]  lines;
   logic [LW-1:0]  pow;
   logic [CW-1:0]  cw;
   logic [IBW-1:0] ib;
   logic [31:0]    addr_m;
   logic [31:0]    set32;
   logic [31:0]    tag32;

   // lines in use, saturated at the directory size
   always_comb begin
      pow = LW'(1) << lines_log2;
      if ({28'd0, lines_log2} >= 32'(LW)) begin
         lines = LW'(MAX_LINES);
      end else if (pow > LW'(MAX_LINES)) begin
         lines = LW'(MAX_LINES);
      end else begin
         lines = pow;
      end
   end

   // associativity clamped to 1..MAX_WAYS and to the lines in use
   always_comb begin
      cw = CW'(ways);
      if (cw == '0) begin
         cw = CW'(1);
      end
      if (cw > CW'(MAX_WAYS)) begin
         cw = CW'(MAX_WAYS);
      end
      if (cw > CW'(lines)) begin
         cw = CW'(lines);
      end
   end

   assign nways = cw[WW-1:0];

   // index bits: largest k with ways shifted by k still within lines
   always_comb begin
      ib = '0;
      for (int k = 0; k < LW; k++) begin
         if ((FW'(nways) << k) <= FW'(lines)) begin
            ib = IBW'(k);
         end
      end
   end

   assign addr_m    = address & AMASK;
   assign line_addr = addr_m & ~OMASK;
   assign set32     = (addr_m >> LSB) & ((32'd1 << ib) - 32'd1);
   assign set_idx   = set32[SW-1:0];
   assign tag32     = addr_m >> (LSB + 32'(ib));
   assign tag       = tag32[TW-1:0];

endmodule

// ===== sv/satd_tag_ram.sv =====
module satd_tag_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 27,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
